/* sv/permutation_unrank_macros.svh */
// ---------------------------------------------------------------------------
// permutation_unrank assertion macros
// Shared concurrent assertion forms for the permutation unranking checker.
// ---------------------------------------------------------------------------
`ifndef PERMUTATION_UNRANK_MACROS_SVH
`define PERMUTATION_UNRANK_MACROS_SVH

// check an implication with the consequent in the same cycle
`define PU_ASSERT_NOW(lbl, clk, rst_n, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) else $error(msg);

// check an implication with the consequent in the next cycle
`define PU_ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

/* sv/pu_pkg.sv */
// ---------------------------------------------------------------------------
// pu_pkg
// Shared constants, types and tables for the permutation unranking block.
// ---------------------------------------------------------------------------
package pu_pkg;

  localparam int MAX_LENGTH = 12;
  localparam int LEN_W      = 4;
  localparam int RANK_W     = 31;
  localparam int FACT_W     = 29;
  localparam int IDX_W      = $clog2(MAX_LENGTH);
  localparam int SHIFT_W    = $clog2(LEN_W);
  localparam int BIT_W      = $clog2(RANK_W);
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [LEN_W-1:0]   LEN_RESET   = LEN_W'(MAX_LENGTH);
  localparam logic [SHIFT_W-1:0] K_TOP       = SHIFT_W'(LEN_W - 1);
  localparam logic               CFG_IDX_LEN = 1'b0;

  typedef enum logic [1:0] {
    DIV_NOP  = 2'd0,
    DIV_LOAD = 2'd1,
    DIV_MOD  = 2'd2,
    DIV_DIG  = 2'd3
  } pu_div_op_t;

  typedef struct packed {
    pu_div_op_t         op;
    logic [SHIFT_W-1:0] k;
  } pu_div_ctl_t;

  typedef struct packed {
    logic init;
    logic place;
  } pu_slot_ctl_t;

  function automatic logic [FACT_W-1:0] fact(input logic [LEN_W-1:0] n);
    logic [FACT_W-1:0] f;
    case (n)
      4'd0:    f = 29'd1;
      4'd1:    f = 29'd1;
      4'd2:    f = 29'd2;
      4'd3:    f = 29'd6;
      4'd4:    f = 29'd24;
      4'd5:    f = 29'd120;
      4'd6:    f = 29'd720;
      4'd7:    f = 29'd5040;
      4'd8:    f = 29'd40320;
      4'd9:    f = 29'd362880;
      4'd10:   f = 29'd3628800;
      4'd11:   f = 29'd39916800;
      4'd12:   f = 29'd479001600;
      default: f = 29'd1;
    endcase
    return f;
  endfunction

  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] v);
    logic [LEN_W-1:0] l;
    l = v;
    if (v == '0) begin
      l = LEN_W'(1);
    end else if (v > LEN_W'(MAX_LENGTH)) begin
      l = LEN_W'(MAX_LENGTH);
    end
    return l;
  endfunction

endpackage

/* sv/permutation_unrank.sv */
// ---------------------------------------------------------------------------
// permutation_unrank
// Turns a rank into a permutation of 1..L by factorial-base digits.
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_rank) takes one rank per transaction.
// Output channel (out_valid/out_ready) then carries L transactions, one per
// slot in position order, with out_last on position L-1.
// L is the perm_length register on the cfg_ APB port (address 0, reset 12;
// 0 acts as 1, above 12 acts as 12). Write it only while the block is idle.
// One shared compare-subtract unit does the division: it reduces the rank
// modulo L! one rank bit a cycle, then extracts each of the L digits one
// quotient bit a cycle and places a value in the free slot the digit selects.
// The block takes a new rank only after the previous rank's last result
// has been taken; in_ready is high only while idle. When the receiver
// stalls, the current result holds and the block waits. Synchronous reset
// (rst_n low) returns to idle, drops any item in flight and sets
// perm_length to 12.
// ---------------------------------------------------------------------------
module permutation_unrank (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [pu_pkg::RANK_W-1:0]       in_rank,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [pu_pkg::LEN_W-1:0]        out_slot_value,
  output logic [pu_pkg::LEN_W-1:0]        out_position,
  output logic                            out_last,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [pu_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [pu_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [pu_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                            cfg_pready
);
  import pu_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MOD   = 5'b00010,
    ST_DIG   = 5'b00100,
    ST_PLACE = 5'b01000,
    ST_OUT   = 5'b10000
  } pu_state_t;

  pu_state_t          state_r, state_nxt;
  logic [LEN_W-1:0]   len_cfg_r, len_cfg_nxt;
  logic [BIT_W-1:0]   bit_r, bit_nxt;
  logic [SHIFT_W-1:0] k_r, k_nxt;
  logic [LEN_W-1:0]   i_r, i_nxt;
  logic [LEN_W-1:0]   pos_r, pos_nxt;

  logic [LEN_W-1:0]   len;
  logic [FACT_W-1:0]  divisor;
  logic [LEN_W-1:0]   digit;
  logic [LEN_W-1:0]   rd_value;
  logic               cfg_wr;
  logic               cfg_idx;
  pu_div_ctl_t        div_ctl;
  pu_slot_ctl_t       slot_ctl;

  assign len     = eff_len(len_cfg_r);
  assign divisor = (state_r == ST_MOD) ? fact(len) : fact(i_r - LEN_W'(1));

  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_idx == CFG_IDX_LEN) ?
                      {(CFG_DATA_W - LEN_W)'(0), len_cfg_r} : '0;

  always_comb begin
    len_cfg_nxt = len_cfg_r;
    if (cfg_wr && cfg_idx == CFG_IDX_LEN) begin
      len_cfg_nxt = cfg_pwdata[LEN_W-1:0];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    bit_nxt        = bit_r;
    k_nxt          = k_r;
    i_nxt          = i_r;
    pos_nxt        = pos_r;
    div_ctl.op     = DIV_NOP;
    div_ctl.k      = k_r;
    slot_ctl.init  = 1'b0;
    slot_ctl.place = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          div_ctl.op    = DIV_LOAD;
          slot_ctl.init = 1'b1;
          bit_nxt       = BIT_W'(RANK_W - 1);
          state_nxt     = ST_MOD;
        end
      end
      ST_MOD: begin
        div_ctl.op = DIV_MOD;
        if (bit_r == '0) begin
          i_nxt     = len;
          k_nxt     = K_TOP;
          state_nxt = ST_DIG;
        end else begin
          bit_nxt = bit_r - BIT_W'(1);
        end
      end
      ST_DIG: begin
        div_ctl.op = DIV_DIG;
        if (k_r == '0) begin
          state_nxt = ST_PLACE;
        end else begin
          k_nxt = k_r - SHIFT_W'(1);
        end
      end
      ST_PLACE: begin
        slot_ctl.place = 1'b1;
        if (i_r == LEN_W'(1)) begin
          pos_nxt   = '0;
          state_nxt = ST_OUT;
        end else begin
          i_nxt     = i_r - LEN_W'(1);
          k_nxt     = K_TOP;
          state_nxt = ST_DIG;
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          if (out_last) begin
            state_nxt = ST_IDLE;
          end else begin
            pos_nxt = pos_r + LEN_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      len_cfg_r <= LEN_RESET;
      bit_r     <= '0;
      k_r       <= '0;
      i_r       <= '0;
      pos_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      len_cfg_r <= len_cfg_nxt;
      bit_r     <= bit_nxt;
      k_r       <= k_nxt;
      i_r       <= i_nxt;
      pos_r     <= pos_nxt;
    end
  end

  pu_divider u_div (
    .clk     (clk),
    .ctl     (div_ctl),
    .rank    (in_rank),
    .divisor (divisor),
    .digit   (digit)
  );

  pu_slots u_slots (
    .clk      (clk),
    .ctl      (slot_ctl),
    .digit    (digit[IDX_W-1:0]),
    .value    (i_r),
    .rd_idx   (pos_r[IDX_W-1:0]),
    .rd_value (rd_value)
  );

  assign in_ready       = (state_r == ST_IDLE);
  assign out_valid      = (state_r == ST_OUT);
  assign out_slot_value = rd_value;
  assign out_position   = pos_r;
  assign out_last       = (pos_r == len - LEN_W'(1));

endmodule

/* sv/pu_divider.sv */
// ---------------------------------------------------------------------------
// pu_divider
// Shared compare-subtract unit: bit-serial rank reduction and digit extraction.
// ---------------------------------------------------------------------------
module pu_divider (
  input  logic                        clk,
  input  pu_pkg::pu_div_ctl_t         ctl,
  input  logic [pu_pkg::RANK_W-1:0]   rank,
  input  logic [pu_pkg::FACT_W-1:0]   divisor,
  output logic [pu_pkg::LEN_W-1:0]    digit
);
  import pu_pkg::*;

  logic [RANK_W-1:0] shift_r, shift_nxt;
  logic [FACT_W-1:0] rem_r, rem_nxt;
  logic [LEN_W-1:0]  digit_r, digit_nxt;
  logic [FACT_W:0]   opa, opb;
  logic [FACT_W+1:0] diff;
  logic              ge;

  always_comb begin
    if (ctl.op == DIV_MOD) begin
      opa = {rem_r, shift_r[RANK_W-1]};
      opb = {1'b0, divisor};
    end else begin
      opa = {1'b0, rem_r};
      opb = {1'b0, divisor} << ctl.k;
    end
    diff = {1'b0, opa} - {1'b0, opb};
    ge   = !diff[FACT_W+1];
  end

  always_comb begin
    shift_nxt = shift_r;
    rem_nxt   = rem_r;
    digit_nxt = digit_r;
    case (ctl.op)
      DIV_LOAD: begin
        shift_nxt = rank;
        rem_nxt   = '0;
      end
      DIV_MOD: begin
        shift_nxt = shift_r << 1;
        rem_nxt   = ge ? diff[FACT_W-1:0] : opa[FACT_W-1:0];
      end
      DIV_DIG: begin
        rem_nxt   = ge ? diff[FACT_W-1:0] : rem_r;
        digit_nxt = ((ctl.k == K_TOP) ? '0 : digit_r) |
                    (ge ? (LEN_W'(1) << ctl.k) : '0);
      end
      default: begin
        shift_nxt = shift_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    rem_r   <= rem_nxt;
    digit_r <= digit_nxt;
  end

  assign digit = digit_r;

endmodule

/* sv/pu_slots.sv */
// ---------------------------------------------------------------------------
// pu_slots
// Ordered list of empty slots and the slot value registers.
// ---------------------------------------------------------------------------
module pu_slots (
  input  logic                       clk,
  input  pu_pkg::pu_slot_ctl_t       ctl,
  input  logic [pu_pkg::IDX_W-1:0]   digit,
  input  logic [pu_pkg::LEN_W-1:0]   value,
  input  logic [pu_pkg::IDX_W-1:0]   rd_idx,
  output logic [pu_pkg::LEN_W-1:0]   rd_value
);
  import pu_pkg::*;

  logic [IDX_W-1:0] free_r   [MAX_LENGTH];
  logic [IDX_W-1:0] free_nxt [MAX_LENGTH];
  logic [LEN_W-1:0] slot_r   [MAX_LENGTH];
  logic [LEN_W-1:0] slot_nxt [MAX_LENGTH];
  logic [IDX_W-1:0] place_pos;

  assign place_pos = free_r[digit];

  always_comb begin
    for (int j = 0; j < MAX_LENGTH; j++) begin
      free_nxt[j] = free_r[j];
      slot_nxt[j] = slot_r[j];
      if (ctl.init) begin
        free_nxt[j] = IDX_W'(j);
      end else if (ctl.place && place_pos == IDX_W'(j)) begin
        slot_nxt[j] = value;
      end
    end
    if (ctl.place && !ctl.init) begin
      for (int j = 0; j < MAX_LENGTH - 1; j++) begin
        if (IDX_W'(j) >= digit) begin
          free_nxt[j] = free_r[j+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_LENGTH; j++) begin
      free_r[j] <= free_nxt[j];
      slot_r[j] <= slot_nxt[j];
    end
  end

  assign rd_value = slot_r[rd_idx];

endmodule

/* sv/pu_checker.sv */
// ---------------------------------------------------------------------------
// pu_checker
// Port-level assertions for permutation_unrank, bound to the top level.
// ---------------------------------------------------------------------------
`include "permutation_unrank_macros.svh"

module pu_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] out_slot_value,
  input logic [3:0] out_position,
  input logic       out_last
);

  `PU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_slot_value) && $stable(out_position) && $stable(out_last), "stalled result changed")

  `PU_ASSERT_NOW(a_one_item, clk, rst_n, out_valid, !in_ready, "input ready while results pending")

  `PU_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && in_ready, !in_ready && !out_valid, "no decode time after accept")

  `PU_ASSERT_NEXT(a_pos_step, clk, rst_n, out_valid && out_ready && !out_last, out_valid && (out_position == $past(out_position) + 4'd1), "position did not advance")

  `PU_ASSERT_NEXT(a_last_idle, clk, rst_n, out_valid && out_ready && out_last, in_ready && !out_valid, "not idle after last result")

endmodule

bind permutation_unrank pu_checker u_pu_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_slot_value (out_slot_value),
  .out_position   (out_position),
  .out_last       (out_last)
);
